// ----- src/crc32c_pkg.sv -----
// crc32c engine package: modes, constants, item types and the byte lookup table
package crc32c_pkg;

  typedef enum logic [1:0] {
    FUNC_RAW   = 2'd0,
    FUNC_BLOCK = 2'd1,
    FUNC_NAME  = 2'd2,
    FUNC_REF   = 2'd3
  } func_t;

  localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] NAME_INIT  = 32'hFFFF_FFFE;
  localparam int          COUNT_W    = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;
  localparam logic [COUNT_W-1:0] REF_BYTES  = 5'd24;
  localparam logic [COUNT_W-1:0] ROOT_BYTES = 5'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [31:0] seed;
  } item_t;

  typedef struct packed {
    logic [63:0] hash;
    logic        length_error;
  } result_t;

  typedef logic [31:0] crc_lut_t [256];

  function automatic crc_lut_t build_lut();
    crc_lut_t t;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_lut_t CRC_LUT = build_lut();

endpackage

// ----- src/crc32c_if.sv -----
// crc32c engine channel interfaces: byte items in, results out
interface crc32c_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic        first;
  logic        last;
  logic [31:0] seed;

  modport source (output valid, output func, output data_byte, output first,
                  output last, output seed, input ready);
  modport sink (input valid, input func, input data_byte, input first,
                input last, input seed, output ready);
endinterface

interface crc32c_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash;
  logic        length_error;

  modport source (output valid, output hash, output length_error, input ready);
  modport sink (input valid, input hash, input length_error, output ready);
endinterface

// ----- src/crc32c_hash_engine_core.sv -----
// crc32c engine top level: byte register, crc update and finish, result buffer
//
//  channel | dir | fields                                  | accepted when
//  req     | in  | func, data_byte, first, last, seed      | req.valid && req.ready
//  rsp     | out | hash, length_error                      | rsp.valid && rsp.ready
//
// one byte per cycle unless a last byte waits for buffer space; a byte is held in the
// input register, then one table lookup and xor update the crc and a finished result
// is written to the result buffer, which holds two results
// rst is synchronous and clears the crc state, mode, count and both buffers
// ready depends only on registers; a stalled rsp stops intake once the buffer is full and a last byte waits
module crc32c_hash_engine_core (
  input  logic          clk,
  input  logic          rst,
  crc32c_in_if.sink     req,
  crc32c_out_if.source  rsp
);

  crc32c_pkg::item_t   s1;
  logic                s1_valid;
  logic                space;
  logic                advance;
  logic                push;

  logic [31:0]                     crc_reg;
  logic [31:0]                     high_part;
  logic [crc32c_pkg::COUNT_W-1:0]  byte_count;
  crc32c_pkg::func_t               mode_reg;

  crc32c_pkg::func_t               mode_next;
  logic [crc32c_pkg::COUNT_W-1:0]  cnt_start;
  logic [crc32c_pkg::COUNT_W-1:0]  byte_count_next;
  logic [31:0]                     crc_start;
  logic [31:0]                     crc_pre;
  logic [31:0]                     crc_reg_next;
  logic [31:0]                     high_start;
  logic [31:0]                     high_part_next;
  logic [7:0]                      tab_idx;
  crc32c_pkg::result_t             result;

  assign advance   = s1_valid && (!s1.last || space);
  assign push      = advance && s1.last;
  assign req.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1.func      <= req.func;
      s1.data_byte <= req.data_byte;
      s1.first     <= req.first;
      s1.last      <= req.last;
      s1.seed      <= req.seed;
    end
  end

  // crc update and finish
  always_comb begin
    if (s1.first) begin
      mode_next  = crc32c_pkg::func_t'(s1.func);
      cnt_start  = '0;
      high_start = '0;
      case (crc32c_pkg::func_t'(s1.func))
        crc32c_pkg::FUNC_RAW:  crc_start = s1.seed;
        crc32c_pkg::FUNC_NAME: crc_start = crc32c_pkg::NAME_INIT;
        default:               crc_start = crc32c_pkg::ALL_ONES;
      endcase
    end else begin
      mode_next  = mode_reg;
      cnt_start  = byte_count;
      high_start = high_part;
      crc_start  = crc_reg;
    end

    // root boundary of a data reference hash
    if (mode_next == crc32c_pkg::FUNC_REF && cnt_start == crc32c_pkg::ROOT_BYTES) begin
      high_part_next = crc_start;
      crc_pre        = crc32c_pkg::ALL_ONES;
    end else begin
      high_part_next = high_start;
      crc_pre        = crc_start;
    end

    tab_idx         = crc_pre[7:0] ^ s1.data_byte;
    crc_reg_next    = crc32c_pkg::CRC_LUT[tab_idx] ^ (crc_pre >> 8);
    byte_count_next = (cnt_start == crc32c_pkg::COUNT_MAX) ? cnt_start
                                                           : cnt_start + 5'd1;

    result.length_error = 1'b0;
    case (mode_next)
      crc32c_pkg::FUNC_BLOCK: result.hash = {32'd0, ~crc_reg_next};
      crc32c_pkg::FUNC_REF: begin
        if (byte_count_next == crc32c_pkg::REF_BYTES) begin
          result.hash = ({32'd0, high_part_next} << 31) ^ {32'd0, crc_reg_next};
        end else begin
          result.hash         = '0;
          result.length_error = 1'b1;
        end
      end
      default: result.hash = {32'd0, crc_reg_next};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= '0;
      high_part  <= '0;
      byte_count <= '0;
      mode_reg   <= crc32c_pkg::FUNC_RAW;
    end else if (advance) begin
      crc_reg    <= crc_reg_next;
      high_part  <= high_part_next;
      byte_count <= byte_count_next;
      mode_reg   <= mode_next;
    end
  end

  crc32c_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .space     (space),
    .rsp       (rsp)
  );

  property p_accept_loads;
    @(posedge clk) disable iff (rst) req.valid && req.ready |=> s1_valid;
  endproperty
  a_accept_loads: assert property (p_accept_loads) else $error("accepted item lost");

  property p_stall_holds;
    @(posedge clk) disable iff (rst) s1_valid && !advance |=> s1_valid && $stable(s1);
  endproperty
  a_stall_holds: assert property (p_stall_holds) else $error("stalled item changed");

  property p_error_zero_hash;
    @(posedge clk) disable iff (rst) rsp.valid && rsp.length_error |-> rsp.hash == '0;
  endproperty
  a_error_zero_hash: assert property (p_error_zero_hash) else $error("error result with hash");

  property p_count_saturates;
    @(posedge clk) disable iff (rst)
      advance && !s1.first && byte_count == crc32c_pkg::COUNT_MAX
      |=> byte_count == crc32c_pkg::COUNT_MAX;
  endproperty
  a_count_saturates: assert property (p_count_saturates) else $error("byte count wrapped");

endmodule

// ----- src/crc32c_out_buf.sv -----
// crc32c engine two-entry result buffer, space flag comes from a register only
module crc32c_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crc32c_pkg::result_t push_data,
  output logic                space,
  crc32c_out_if.source        rsp
);

  logic [1:0]          count;
  crc32c_pkg::result_t e0;
  crc32c_pkg::result_t e1;
  logic                pop;

  assign pop              = rsp.valid && rsp.ready;
  assign rsp.valid        = (count != 2'd0);
  assign rsp.hash         = e0.hash;
  assign rsp.length_error = e0.length_error;
  assign space            = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          e0 <= push_data;
        end else begin
          e1 <= push_data;
        end
      end
      2'b01: begin
        e0 <= e1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          e0 <= push_data;
        end else begin
          e0 <= e1;
          e1 <= push_data;
        end
      end
      default: begin
        e0 <= e0;
      end
    endcase
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) push |-> (space || pop);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("result pushed into full buffer");

  property p_count_range;
    @(posedge clk) disable iff (rst) count != 2'd3;
  endproperty
  a_count_range: assert property (p_count_range) else $error("buffer count out of range");

  property p_head_held;
    @(posedge clk) disable iff (rst) rsp.valid && !rsp.ready |=> rsp.valid && $stable(e0);
  endproperty
  a_head_held: assert property (p_head_held) else $error("waiting result changed");

endmodule

// ----- tb/testbench.sv -----
// testbench for crc32c_hash_engine_core: directed table, random messages, in-line crc predictor
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    crc32c_pkg::item_t   stim;
    bit                  fixed;
    crc32c_pkg::result_t want;
  } row_t;

  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES       = 4;

  logic clk;
  logic rst;

  crc32c_in_if  req_if ();
  crc32c_out_if rsp_if ();

  crc32c_hash_engine_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // predictor state
  crc32c_pkg::func_t   mode_q;
  logic [31:0]         crc_q;
  logic [31:0]         root_crc_q;
  logic [4:0]          count_q;

  crc32c_pkg::result_t pending_hashes [$];
  int                  mismatches;
  int                  items_sent;
  int                  send_idle_pct;
  int                  rsp_stall_pct;

  row_t directed_rows [19] = '{
    '{'{crc32c_pkg::FUNC_RAW,   8'h00, 1'b0, 1'b1, 32'h0000_0000}, 1'b1, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_REF,   8'hFF, 1'b1, 1'b1, 32'h0000_0000}, 1'b1, '{64'h0, 1'b1}},
    '{'{crc32c_pkg::FUNC_BLOCK, 8'h31, 1'b1, 1'b0, 32'hFFFF_FFFF}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_BLOCK, 8'h32, 1'b0, 1'b0, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_NAME,  8'h33, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_RAW,   8'h34, 1'b0, 1'b0, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_REF,   8'h35, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_BLOCK, 8'h36, 1'b0, 1'b0, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_BLOCK, 8'h37, 1'b0, 1'b0, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_BLOCK, 8'h38, 1'b0, 1'b0, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_BLOCK, 8'h39, 1'b0, 1'b1, 32'h0000_0000}, 1'b1,
      '{64'hE306_9283, 1'b0}},
    '{'{crc32c_pkg::FUNC_RAW,   8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b1,
      '{64'h00FF_FFFF, 1'b0}},
    '{'{crc32c_pkg::FUNC_NAME,  8'h00, 1'b1, 1'b1, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_REF,   8'hA5, 1'b0, 1'b0, 32'h1234_5678}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_RAW,   8'h5A, 1'b0, 1'b1, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_RAW,   8'h00, 1'b1, 1'b0, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_BLOCK, 8'h80, 1'b0, 1'b1, 32'hFFFF_FFFF}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_REF,   8'h00, 1'b1, 1'b0, 32'h0000_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{crc32c_pkg::FUNC_REF,   8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF}, 1'b1, '{64'h0, 1'b1}}
  };

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [31:0] crc32c_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ crc32c_pkg::CRC_POLY) : (c >> 1);
    end
    return c ^ (crc >> 8);
  endfunction

  task automatic hash_byte(input crc32c_pkg::item_t it, output bit produced,
                           output crc32c_pkg::result_t res);
    if (it.first) begin
      mode_q     = crc32c_pkg::func_t'(it.func);
      count_q    = '0;
      root_crc_q = '0;
      case (crc32c_pkg::func_t'(it.func))
        crc32c_pkg::FUNC_RAW:  crc_q = it.seed;
        crc32c_pkg::FUNC_NAME: crc_q = crc32c_pkg::NAME_INIT;
        default:               crc_q = crc32c_pkg::ALL_ONES;
      endcase
    end
    // root done: park its crc and restart for owner and offset
    if (mode_q == crc32c_pkg::FUNC_REF && count_q == crc32c_pkg::ROOT_BYTES) begin
      root_crc_q = crc_q;
      crc_q      = crc32c_pkg::ALL_ONES;
    end
    crc_q = crc32c_step(crc_q, it.data_byte);
    if (count_q < crc32c_pkg::COUNT_MAX) begin
      count_q = count_q + 5'd1;
    end
    produced = it.last;
    res      = '0;
    case (mode_q)
      crc32c_pkg::FUNC_BLOCK: res.hash = {32'h0, ~crc_q};
      crc32c_pkg::FUNC_REF: begin
        if (count_q == crc32c_pkg::REF_BYTES) begin
          res.hash = ({32'h0, root_crc_q} << 31) ^ {32'h0, crc_q};
        end else begin
          res.length_error = 1'b1;
        end
      end
      default: res.hash = {32'h0, crc_q};
    endcase
  endtask

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    if (mismatches < 10) begin
      $display("mismatch %0t: %s expected %h got %h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  task automatic check_result();
    crc32c_pkg::result_t want;
    if (pending_hashes.size() == 0) begin
      report("unexpected item, hash", 64'h0, rsp_if.hash);
    end else begin
      want = pending_hashes.pop_front();
      if (rsp_if.hash !== want.hash) begin
        report("hash", want.hash, rsp_if.hash);
      end
      if (rsp_if.length_error !== want.length_error) begin
        report("length_error", 64'(want.length_error), 64'(rsp_if.length_error));
      end
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input crc32c_pkg::item_t it, input bit fixed,
                           input crc32c_pkg::result_t want);
    bit                  produced;
    crc32c_pkg::result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    {req_if.func, req_if.data_byte, req_if.first, req_if.last, req_if.seed} = it;
    req_if.valid = 1'b1;
    @(posedge clk);
    while (!req_if.ready) begin
      @(posedge clk);
    end
    hash_byte(it, produced, res);
    if (produced) begin
      pending_hashes.push_back(fixed ? want : res);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input crc32c_pkg::func_t mode, input int len, input bit noise);
    crc32c_pkg::item_t it;
    int                roll;
    for (int i = 0; i < len; i++) begin
      roll         = $urandom_range(99);
      it.data_byte = 8'($urandom);
      it.seed      = (roll < 10) ? 32'h0 : (roll < 20) ? crc32c_pkg::ALL_ONES : $urandom;
      if (noise) begin
        it.func  = 2'($urandom);
        it.first = ($urandom_range(3) == 0);
        it.last  = ($urandom_range(3) == 0);
      end else begin
        it.func  = (i == 0) ? mode : 2'($urandom);
        it.first = (i == 0);
        it.last  = (i == len - 1);
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // result side: stall at random, check at the rising edge
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = !rst && ($urandom_range(99) >= rsp_stall_pct);
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        check_result();
      end
    end
  end

  initial begin
    int roll;
    int len;
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    {req_if.func, req_if.data_byte, req_if.first, req_if.last, req_if.seed} = '0;
    mode_q          = crc32c_pkg::FUNC_RAW;
    crc_q           = '0;
    root_crc_q      = '0;
    count_q         = '0;
    mismatches      = 0;
    items_sent      = 0;
    send_idle_pct   = 0;
    rsp_stall_pct   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
        default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
      endcase
      while (items_sent < $size(directed_rows) + RANDOM_ITEMS * (ph + 1) / PHASES) begin
        roll = $urandom_range(99);
        if (roll < 45) begin
          send_message(crc32c_pkg::FUNC_REF, 24, 1'b0);
        end else if (roll < 55) begin
          // short, one-off and saturating reference lengths
          len = $urandom_range(1, 40);
          if (len == 24) begin
            len = ($urandom_range(1) == 0) ? 23 : 25;
          end
          send_message(crc32c_pkg::FUNC_REF, len, 1'b0);
        end else if (roll < 85) begin
          send_message(crc32c_pkg::func_t'($urandom_range(2)), $urandom_range(1, 12), 1'b0);
        end else begin
          send_message(crc32c_pkg::FUNC_RAW, $urandom_range(1, 6), 1'b1);
        end
      end
    end
    req_if.valid = 1'b0;

    while (pending_hashes.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
